### hw/rtl/mih_pkg.sv
// Message id handler table: shared types and fixed field widths.
// No dependencies; imported by the channel interfaces, the table module and its testbench.
`default_nettype none

package mih_pkg;

    localparam int KEY_W      = 32;
    localparam int GROUP_W    = 18;
    localparam int CODE_W     = 8;
    localparam int CODE_SHIFT = 24;
    localparam int HANDLER_W  = 16;
    localparam int SLOT_OUT_W = 5;
    localparam int STATUS_W   = 2;

    // home slot is computed HASH_DIGIT key bits per hash step
    localparam int HASH_DIGIT = 4;
    localparam int HASH_STEPS = KEY_W / HASH_DIGIT;
    localparam int HASH_CW    = $clog2(HASH_STEPS);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_status                 status;
        logic                    found;
        logic [HANDLER_W-1:0]    handler_out;
        logic [SLOT_OUT_W-1:0]   slot;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/mih_if.sv
// Valid/ready channels of the message id handler table: command and response.
// Depends on mih_pkg for the operation and status codes.
`default_nettype none

interface mih_cmd_if
    import mih_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_op                  operation;
    logic [GROUP_W-1:0]   group_number;
    logic [CODE_W-1:0]    sub_code;
    logic [HANDLER_W-1:0] handler_in;

    modport source (output valid, operation, group_number, sub_code, handler_in,
                    input ready);
    modport sink   (input valid, operation, group_number, sub_code, handler_in,
                    output ready);
endinterface

interface mih_rsp_if
    import mih_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic                  found;
    logic [HANDLER_W-1:0]  handler_out;
    logic [SLOT_OUT_W-1:0] slot;

    modport source (output valid, status, found, handler_out, slot, input ready);
    modport sink   (input valid, status, found, handler_out, slot, output ready);
endinterface

`default_nettype wire

### hw/rtl/message_id_handler_table.sv
// Message id handler table: linear-probing hash table, key -> handler id.
// A word runs through the hash steps, the probes, the decide state and the response register;
// clear and insert into a full table go straight to the response. A response stall holds the sequencer.
// A new word is taken only while the sequencer is idle, once the previous word has reached the response register.
// Reset: valid bits, entry count, sequencer and response valid clear; RAMs are not cleared.
// Depends on mih_pkg, mih_if (channels) and mih_ram.
`default_nettype none

module message_id_handler_table
    import mih_pkg::*;
#(
    parameter int TABLE_SLOTS  = 32,
    parameter int HANDLER_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mih_cmd_if.sink    i_cmd,
    mih_rsp_if.source  o_rsp
);

    localparam int AW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int PAD = CODE_SHIFT - GROUP_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HASH   = 5'b00010,
        S_PROBE  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [TABLE_SLOTS-1:0]  r_valid;
    logic [CW-1:0]           r_count;
    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 r_res;

    t_op                     r_op;
    logic [KEY_W-1:0]        r_key;
    logic [KEY_W-1:0]        r_key_sh;
    logic [HANDLER_BITS-1:0] r_hin;
    logic [HASH_CW-1:0]      r_hash_cnt;
    logic [AW-1:0]           r_rem;
    logic [AW-1:0]           n_rem;

    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_cnt;
    logic [AW-1:0]           r_cmp_pos;
    logic                    r_cmp_live;
    logic                    r_hit;
    logic [AW-1:0]           r_hit_pos;
    logic [HANDLER_BITS-1:0] r_hit_hdl;
    logic                    r_empty;
    logic [AW-1:0]           r_empty_pos;

    logic [KEY_W-1:0]        w_key_in;
    logic [31:0]             w_hin_ext;
    logic [KEY_W-1:0]        w_key_rd;
    logic [HANDLER_BITS-1:0] w_hdl_rd;
    logic                    w_accept;
    logic                    w_full_ins;
    logic                    w_issue;
    logic                    w_hit_now;
    logic                    w_empty_now;
    logic                    w_we;
    logic [AW-1:0]           w_pos_next;
    logic [31:0]             w_hit_pos_ext;
    logic [31:0]             w_empty_pos_ext;
    logic [31:0]             w_hit_hdl_ext;
    logic                    w_out_free;

    assign w_key_in  = {i_cmd.sub_code, {PAD{1'b0}}, i_cmd.group_number};
    assign w_hin_ext = 32'(i_cmd.handler_in);
    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_full_ins  = (i_cmd.operation == OP_INSERT) && (r_count >= CW'(TABLE_SLOTS));

    assign w_issue     = (r_state == S_PROBE) && (r_cnt != CW'(TABLE_SLOTS));
    assign w_pos_next  = (r_pos == AW'(TABLE_SLOTS - 1)) ? '0 : r_pos + 1'b1;
    assign w_hit_now   = r_cmp_live && r_valid[r_cmp_pos] && (w_key_rd == r_key);
    assign w_empty_now = r_cmp_live && !r_valid[r_cmp_pos];
    assign w_we        = (r_state == S_DECIDE) && (r_op == OP_INSERT) && !r_hit && r_empty;

    assign w_hit_pos_ext   = 32'(r_hit_pos);
    assign w_empty_pos_ext = 32'(r_empty_pos);
    assign w_hit_hdl_ext   = 32'(r_hit_hdl);
    assign w_out_free      = !r_out_valid || o_rsp.ready;

    mih_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_empty_pos),
        .i_wdata (r_key),
        .i_raddr (r_pos),
        .o_rdata (w_key_rd)
    );

    mih_ram #(.WIDTH(HANDLER_BITS), .DEPTH(TABLE_SLOTS)) u_hdl_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_empty_pos),
        .i_wdata (r_hin),
        .i_raddr (r_pos),
        .o_rdata (w_hdl_rd)
    );

    // remainder of key by TABLE_SLOTS, HASH_DIGIT bits per step, MSB first
    always_comb begin
        logic [AW:0] t;
        n_rem = r_rem;
        for (int j = 0; j < HASH_DIGIT; j++) begin
            t = {n_rem, r_key_sh[KEY_W-1-j]};
            if (t >= (AW+1)'(TABLE_SLOTS)) begin
                t = t - (AW+1)'(TABLE_SLOTS);
            end
            n_rem = t[AW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.operation == OP_CLEAR) begin
                        n_state = S_FIN;
                    end else if (w_full_ins) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (r_hash_cnt == HASH_CW'(HASH_STEPS - 1)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!w_issue) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_live  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_live <= w_issue;
            if (w_accept && i_cmd.operation == OP_CLEAR) begin
                r_valid <= '0;
                r_count <= '0;
            end
            if (r_state == S_DECIDE) begin
                if (w_we) begin
                    r_valid[r_empty_pos] <= 1'b1;
                    r_count              <= r_count + 1'b1;
                end else if (r_op == OP_DELETE && r_hit) begin
                    r_valid[r_hit_pos] <= 1'b0;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_cmd.operation;
            r_key      <= w_key_in;
            r_key_sh   <= w_key_in;
            r_hin      <= w_hin_ext[HANDLER_BITS-1:0];
            r_hash_cnt <= '0;
            r_rem      <= '0;
            r_hit      <= 1'b0;
            r_empty    <= 1'b0;
            r_res      <= '{status: (w_full_ins ? ST_FULL : ST_OK), found: 1'b0,
                            handler_out: '0, slot: '0};
        end
        if (r_state == S_HASH) begin
            r_rem      <= n_rem;
            r_key_sh   <= r_key_sh << HASH_DIGIT;
            r_hash_cnt <= r_hash_cnt + 1'b1;
            r_pos      <= n_rem;
            r_cnt      <= '0;
        end
        if (w_issue) begin
            r_cmp_pos <= r_pos;
            r_pos     <= w_pos_next;
            r_cnt     <= r_cnt + 1'b1;
        end
        if (w_hit_now && !r_hit) begin
            r_hit     <= 1'b1;
            r_hit_pos <= r_cmp_pos;
            r_hit_hdl <= w_hdl_rd;
        end
        if (w_empty_now && !r_empty) begin
            r_empty     <= 1'b1;
            r_empty_pos <= r_cmp_pos;
        end
        if (r_state == S_DECIDE) begin
            unique case (r_op)
                OP_INSERT: begin
                    if (r_hit) begin
                        r_res.status <= ST_DUPLICATE;
                    end else if (!r_empty) begin
                        r_res.status <= ST_FULL;
                    end else begin
                        r_res.slot <= w_empty_pos_ext[SLOT_OUT_W-1:0];
                    end
                end
                OP_DELETE: begin
                    if (r_hit) begin
                        r_res.slot <= w_hit_pos_ext[SLOT_OUT_W-1:0];
                    end else begin
                        r_res.status <= ST_UNKNOWN;
                    end
                end
                OP_LOOKUP: begin
                    if (r_hit) begin
                        r_res.found       <= 1'b1;
                        r_res.handler_out <= w_hit_hdl_ext[HANDLER_W-1:0];
                        r_res.slot        <= w_hit_pos_ext[SLOT_OUT_W-1:0];
                    end else begin
                        r_res.status <= ST_UNKNOWN;
                    end
                end
                default: r_res.status <= ST_OK;
            endcase
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.handler_out = r_out.handler_out;
    assign o_rsp.slot        = r_out.slot;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SLOTS))
        else $error("entry count above table size");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("entry count differs from number of valid slots");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while a word is in progress");
`endif

endmodule

`default_nettype wire

### hw/rtl/mih_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the key and handler stores of the table.
`default_nettype none

module mih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### dv/tb_message_id_handler_table.sv
// Testbench for message_id_handler_table: drives insert, delete, lookup and clear words,
// predicts each response with its own copy of the hash table, and compares field by field.
// Depends on mih_pkg, mih_if and the table RTL.
`timescale 1ns / 1ps

module tb_message_id_handler_table;
    import mih_pkg::*;

    localparam int NSLOTS      = 32;
    localparam int HBITS       = 16;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 80;
    localparam logic [HANDLER_W-1:0] HMASK = HANDLER_W'((64'd1 << HBITS) - 1);

    typedef struct {
        t_op                  op;
        logic [GROUP_W-1:0]   grp;
        logic [CODE_W-1:0]    code;
        logic [HANDLER_W-1:0] hin;
    } msg_cmd_t;

    logic i_clk;
    logic i_rst_n;

    mih_cmd_if cmd_ch();
    mih_rsp_if rsp_ch();

    message_id_handler_table #(
        .TABLE_SLOTS (NSLOTS),
        .HANDLER_BITS(HBITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    // predicted hash table contents
    logic [KEY_W-1:0]     pred_key [NSLOTS];
    logic [HANDLER_W-1:0] pred_handler [NSLOTS];
    bit                   pred_used [NSLOTS];
    int                   pred_count;

    msg_cmd_t cmd_backlog[$];
    t_result  rsp_due[$];

    bit cmd_taken;
    bit src_idle_en;
    bit snk_idle_en;
    int src_gap;
    int snk_stall;
    int cycle_cnt;
    int err_cnt;
    int words_made;
    int op_seen [4];
    int status_seen [4];
    int lookup_hits;

    function automatic int find_slot(logic [KEY_W-1:0] key);
        int pos;
        for (int n = 0; n < NSLOTS; n++) begin
            pos = (int'(key % NSLOTS) + n) % NSLOTS;
            if (pred_used[pos] && pred_key[pos] == key)
                return pos;
        end
        return NSLOTS;
    endfunction

    function automatic t_result predict_handler_result(msg_cmd_t c);
        logic [KEY_W-1:0] key;
        int               pos;
        int               hit;
        t_result          r;
        key = {c.code, 6'd0, c.grp};
        hit = find_slot(key);
        r = '{ST_OK, 1'b0, '0, '0};
        case (c.op)
            OP_INSERT: begin
                if (pred_count >= NSLOTS) begin
                    r.status = ST_FULL;
                end else if (hit != NSLOTS) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    pos = int'(key % NSLOTS);
                    while (pred_used[pos])
                        pos = (pos + 1) % NSLOTS;
                    pred_key[pos]     = key;
                    pred_handler[pos] = c.hin & HMASK;
                    pred_used[pos]    = 1'b1;
                    pred_count++;
                    r.slot = SLOT_OUT_W'(pos);
                end
            end
            OP_DELETE: begin
                if (hit == NSLOTS) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    pred_used[hit] = 1'b0;
                    if (pred_count > 0)
                        pred_count--;
                    r.slot = SLOT_OUT_W'(hit);
                end
            end
            OP_LOOKUP: begin
                if (hit == NSLOTS) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.found       = 1'b1;
                    r.handler_out = pred_handler[hit];
                    r.slot        = SLOT_OUT_W'(hit);
                end
            end
            default: begin
                for (int i = 0; i < NSLOTS; i++)
                    pred_used[i] = 1'b0;
                pred_count = 0;
            end
        endcase
        return r;
    endfunction

    task automatic report_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // command driver
    always @(negedge i_clk) begin
        msg_cmd_t nxt;
        bit       drive_v;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            drive_v = cmd_ch.valid && !cmd_taken;
            if (cmd_taken) begin
                cmd_taken = 1'b0;
                if (src_idle_en && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 7);
            end
            if (!drive_v) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (cmd_backlog.size() > 0) begin
                    nxt = cmd_backlog.pop_front();
                    cmd_ch.operation    <= nxt.op;
                    cmd_ch.group_number <= nxt.grp;
                    cmd_ch.sub_code     <= nxt.code;
                    cmd_ch.handler_in   <= nxt.hin;
                    drive_v = 1'b1;
                end
            end
            cmd_ch.valid <= drive_v;
        end
    end

    // response backpressure
    always @(negedge i_clk) begin
        if (snk_stall > 0) begin
            snk_stall--;
            rsp_ch.ready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            snk_stall = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted commands, check accepted responses
    always @(posedge i_clk) begin
        msg_cmd_t acc;
        t_result  act;
        t_result  exp_r;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("message_id_handler_table verification failed");
            $finish;
        end
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                acc = '{cmd_ch.operation, cmd_ch.group_number, cmd_ch.sub_code,
                        cmd_ch.handler_in};
                rsp_due.push_back(predict_handler_result(acc));
                op_seen[acc.op]++;
                cmd_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                act = '{rsp_ch.status, rsp_ch.found, rsp_ch.handler_out, rsp_ch.slot};
                if (rsp_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %p", $time, act);
                    err_cnt++;
                end else begin
                    exp_r = rsp_due.pop_front();
                    report_field("status", exp_r.status, act.status);
                    report_field("found", exp_r.found, act.found);
                    report_field("handler_out", exp_r.handler_out, act.handler_out);
                    report_field("slot", exp_r.slot, act.slot);
                    status_seen[exp_r.status]++;
                    if (exp_r.found)
                        lookup_hits++;
                end
            end
        end
    end

    task automatic push_cmd(t_op op, logic [GROUP_W-1:0] g, logic [CODE_W-1:0] c,
                            logic [HANDLER_W-1:0] h);
        cmd_backlog.push_back('{op, g, c, h});
        words_made++;
    endtask

    task automatic wait_table_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (cmd_backlog.size() != 0 || cmd_ch.valid || rsp_due.size() != 0);
    endtask

    task automatic wait_backlog_low();
        while (cmd_backlog.size() > 4)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        push_cmd(OP_INSERT, 18'h0, 8'h00, 16'h0000);
        push_cmd(OP_LOOKUP, 18'h0, 8'h00, 16'hFFFF);
        push_cmd(OP_INSERT, 18'h0, 8'h00, 16'hFFFF);
        push_cmd(OP_INSERT, 18'h3FFFF, 8'hFF, 16'hFFFF);
        push_cmd(OP_LOOKUP, 18'h3FFFF, 8'hFF, 16'h0000);
        // same home as the max key, wraps past slot 0
        push_cmd(OP_INSERT, 18'h0001F, 8'h00, 16'h1234);
        push_cmd(OP_LOOKUP, 18'h0001F, 8'h00, 16'h0000);
        push_cmd(OP_DELETE, 18'h0, 8'h00, 16'hAAAA);
        push_cmd(OP_LOOKUP, 18'h0001F, 8'h00, 16'h0000);
        push_cmd(OP_DELETE, 18'h0, 8'h00, 16'h0000);
        push_cmd(OP_LOOKUP, 18'h0, 8'h00, 16'h0000);
        push_cmd(OP_INSERT, 18'h0, 8'h80, 16'h8001);
        push_cmd(OP_INSERT, 18'h00020, 8'h00, 16'h5A5A);
        push_cmd(OP_LOOKUP, 18'h00020, 8'h00, 16'h0000);
        push_cmd(OP_LOOKUP, 18'h00020, 8'h01, 16'h0000);
        push_cmd(OP_DELETE, 18'h00020, 8'h00, 16'hFFFF);
        push_cmd(OP_CLEAR, 18'h3FFFF, 8'hFF, 16'hFFFF);
        push_cmd(OP_LOOKUP, 18'h3FFFF, 8'hFF, 16'h0000);
        push_cmd(OP_DELETE, 18'h0001F, 8'h00, 16'h0000);
        push_cmd(OP_INSERT, 18'h2AAAA, 8'h55, 16'hA5A5);
        push_cmd(OP_LOOKUP, 18'h2AAAA, 8'h55, 16'h0000);
        push_cmd(OP_CLEAR, 18'h0, 8'h00, 16'h0000);
    endtask

    // clear, then fill every slot from two crowded homes and overflow
    task automatic run_fill();
        logic [GROUP_W-1:0] fg [36];
        logic [CODE_W-1:0]  fc [36];
        logic [4:0]         h0;
        logic [4:0]         h1;
        logic [12:0]        base;
        int                 k;
        h0   = 5'($urandom);
        h1   = 5'($urandom);
        base = 13'($urandom);
        for (int i = 0; i < 36; i++) begin
            fg[i] = {13'(base + 13'(i)), ($urandom_range(0, 1) ? h0 : h1)};
            fc[i] = 8'($urandom);
        end
        push_cmd(OP_CLEAR, 18'($urandom), 8'($urandom), 16'($urandom));
        for (int i = 0; i < 33; i++)
            push_cmd(OP_INSERT, fg[i], fc[i], 16'($urandom));
        for (int i = 0; i < 4; i++) begin
            k = $urandom_range(0, 32);
            push_cmd(OP_LOOKUP, fg[k], fc[k], 16'($urandom));
        end
        for (int i = 0; i < 3; i++) begin
            k = $urandom_range(0, 32);
            push_cmd(OP_DELETE, fg[k], fc[k], 16'($urandom));
        end
        push_cmd(OP_INSERT, fg[33], fc[33], 16'($urandom));
        push_cmd(OP_INSERT, fg[34], fc[34], 16'($urandom));
        k = $urandom_range(0, 31);
        push_cmd(OP_INSERT, fg[k], fc[k], 16'($urandom));
        push_cmd(OP_INSERT, fg[35], fc[35], 16'($urandom));
        for (int i = 0; i < 4; i++) begin
            k = $urandom_range(0, 35);
            push_cmd(OP_LOOKUP, fg[k], fc[k], 16'($urandom));
        end
    endtask

    // random traffic over a small key pool crowded onto four homes, plus fully random words
    task automatic run_churn(int n);
        logic [GROUP_W-1:0] pg [40];
        logic [CODE_W-1:0]  pc [40];
        logic [4:0]         homes [4];
        int                 r;
        int                 k;
        for (int i = 0; i < 4; i++)
            homes[i] = 5'($urandom);
        for (int i = 0; i < 40; i++) begin
            pg[i] = {13'($urandom_range(0, 7)), homes[$urandom_range(0, 3)]};
            pc[i] = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
                pg[i][17:5] = 13'($urandom);
                pc[i]       = 8'($urandom);
            end
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 39);
            if (r < 45)
                push_cmd(OP_INSERT, pg[k], pc[k], 16'($urandom));
            else if (r < 65)
                push_cmd(OP_DELETE, pg[k], pc[k], 16'($urandom));
            else if (r < 89)
                push_cmd(OP_LOOKUP, pg[k], pc[k], 16'($urandom));
            else if (r < 90)
                push_cmd(OP_CLEAR, pg[k], pc[k], 16'($urandom));
            else
                push_cmd(t_op'($urandom_range(0, 3)), 18'($urandom), 8'($urandom),
                         16'($urandom));
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_INSERT;
        cmd_ch.group_number = '0;
        cmd_ch.sub_code     = '0;
        cmd_ch.handler_in   = '0;
        rsp_ch.ready        = 1'b0;
        src_idle_en         = 1'b1;
        snk_idle_en         = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        wait_table_idle();
        while (words_made < ITEM_TARGET) begin
            wait_backlog_low();
            if (words_made > ITEM_TARGET * 85 / 100) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end else begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                snk_idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) == 0)
                run_fill();
            else
                run_churn($urandom_range(40, 90));
            if ($urandom_range(0, 3) == 0)
                wait_table_idle();
        end
        wait_table_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d words: %0d inserts, %0d deletes, %0d lookups, %0d clears",
                 words_made, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_LOOKUP],
                 op_seen[OP_CLEAR]);
        $display("Responses: %0d ok, %0d unknown, %0d duplicate, %0d full, %0d lookup hits",
                 status_seen[ST_OK], status_seen[ST_UNKNOWN], status_seen[ST_DUPLICATE],
                 status_seen[ST_FULL], lookup_hits);
        if (err_cnt == 0) begin
            $display("message_id_handler_table verification clean");
        end else begin
            $display("message_id_handler_table verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mih_pkg.sv
hw/rtl/mih_if.sv
hw/rtl/mih_ram.sv
hw/rtl/message_id_handler_table.sv
dv/tb_message_id_handler_table.sv
